// ----- src/crps_pkg.sv -----
// Shared types and constants of the Catmull-Rom path stepper.
package crps_pkg;

  localparam int MAX_POINTS_DEF = 256;
  localparam int COORD_BITS_DEF = 32;

  // One in Q1.16
  localparam logic [16:0] T_ONE = 17'h10000;

  // Configuration register indexes
  localparam logic [1:0] REG_STEP_SIZE   = 2'd0;
  localparam logic [1:0] REG_END_STEP    = 2'd1;
  localparam logic [1:0] REG_POINT_COUNT = 2'd2;

  typedef enum logic [1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_RESTART = 2'd1,
    FUNC_FWD     = 2'd2,
    FUNC_BACK    = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CHORD,
    ST_SQ,
    ST_SQRT,
    ST_CHK,
    ST_DIV,
    ST_INC,
    ST_PLACE,
    ST_EVAL,
    ST_DONE
  } state_t;

  // What t becomes once a new increment is known
  typedef enum logic [1:0] {
    TM_KEEP,
    TM_INC,
    TM_SNAP
  } tmode_t;

  typedef struct packed {
    func_t              func;
    logic [7:0]         point_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } in_item_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [7:0]         segment;
    logic [17:0]        param;
  } out_item_t;

endpackage

// ----- src/catmull_rom_path_stepper.sv -----
// Catmull-Rom path stepper: point memories, sequencer and serial arithmetic.
//
// The block holds up to MAX_POINTS path points (x and y in two synchronous
// memories) and walks a position along a uniform Catmull-Rom spline through
// them. Each command transfer yields exactly one result transfer carrying
// ok, the position, the segment and t after the command. One command is
// worked on at a time; a new command is taken as soon as the previous
// result sits in the output register, even if it has not been taken yet.
// A load writes one point into both memories. A step that stays on its
// segment does four memory reads of the control points, then a Horner
// evaluation of x and y with one multiply by t per cycle. A step that
// changes segment (and a restart) also recomputes the t increment:
// bit-serial squaring of the chord, a one-bit-per-cycle square root and a
// restoring divide of 16 quotient bits, the divide only when the step is
// shorter than the chord; a backward segment change adds a second divide
// to snap t onto the increment grid. The point memories are not cleared;
// read only points that were loaded. The configuration port is always
// ready; it is to be written only while the block is idle, which the
// block itself does not enforce.
module catmull_rom_path_stepper #(
  parameter int MAX_POINTS = crps_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = crps_pkg::COORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  crps_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output crps_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  localparam int CB   = COORD_BITS;
  localparam int AW   = $clog2(MAX_POINTS);
  localparam int RW   = CB + 1;             // chord length width
  localparam int NW   = 2 * RW;             // squared length width
  localparam int DVW  = RW + 1;             // divider remainder width
  localparam int HW   = CB + 6;             // Horner accumulator width
  localparam int PW   = HW + 18;            // product by t
  localparam int CNTW = $clog2(CB + 2);
  localparam int CW   = (RW > 31) ? RW : 31;

  // Point memories: one address per cycle, registered read data
  logic signed [CB-1:0] mem_x [MAX_POINTS];
  logic signed [CB-1:0] mem_y [MAX_POINTS];
  logic signed [CB-1:0] rd_x_r, rd_y_r;
  logic [AW-1:0]        mem_addr;
  logic                 mem_we;

  crps_pkg::state_t     state_r, state_nxt;
  logic [CNTW-1:0]      cnt_r, cnt_nxt;
  logic [7:0]           seg_r, seg_nxt;
  logic [16:0]          t_r, t_nxt;
  logic [16:0]          inc_r, inc_nxt;
  logic signed [CB-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [30:0]          step_r, step_nxt, end_r, end_nxt;
  logic [8:0]           pc_r, pc_nxt;
  logic                 ok_r, ok_nxt;
  logic                 need_inc_r, need_inc_nxt;
  crps_pkg::tmode_t     tmode_r, tmode_nxt;
  logic [30:0]          tgt_r, tgt_nxt;
  logic signed [CB-1:0] pm_x_r, p0_x_r, p1_x_r, p2_x_r;
  logic signed [CB-1:0] pm_y_r, p0_y_r, p1_y_r, p2_y_r;
  logic signed [CB-1:0] pm_x_nxt, p0_x_nxt, p1_x_nxt, p2_x_nxt;
  logic signed [CB-1:0] pm_y_nxt, p0_y_nxt, p1_y_nxt, p2_y_nxt;
  logic                 rvld_r;
  logic [NW-1:0]        acc_r, acc_nxt, sqa_r, sqa_nxt;
  logic [CB:0]          sqb_r, sqb_nxt;
  logic                 pass_r, pass_nxt;
  logic [RW-1:0]        root_r, root_nxt;
  logic [RW+1:0]        srem_r, srem_nxt;
  logic [DVW-1:0]       drem_r, drem_nxt;
  logic [15:0]          q_r, q_nxt;
  logic                 div_snap_r, div_snap_nxt;
  logic signed [HW-1:0] hacc_r, hacc_nxt;
  logic                 coord_r, coord_nxt;
  logic                 out_valid_r, out_valid_nxt;
  crps_pkg::out_item_t  out_data_r, out_data_nxt;

  // Fetch address: entry seg-1+cnt, zero outside the store
  logic [9:0]  fetch_j, fetch_idx;
  logic        fetch_ok;
  logic        in_xfer;
  logic        load_ok;

  logic [9:0]  seg10, pc10;
  logic [17:0] tsum;
  logic [16:0] tdiff;
  logic [7:0]  seg_up, seg_dn;

  logic signed [CB:0]   dx_s, dy_s;
  logic [CB:0]          dx_m, dy_m;
  logic [RW+1:0]        rem_sh, trial;
  logic [DVW-1:0]       dsh, dvs;
  logic [15:0]          q_fin;
  logic signed [CB-1:0] rdx, rdy;

  logic signed [HW-1:0] a_x, a_y, coef;
  logic signed [PW-1:0] prod;
  logic signed [HW-1:0] mt, hsum, half;
  logic signed [CB-1:0] sat;

  function automatic logic signed [HW-1:0] ext(input logic signed [CB-1:0] v);
    ext = HW'(v);
  endfunction

  function automatic logic signed [HW-1:0] coef_a(
    input logic signed [CB-1:0] pm, p0, p1, p2
  );
    logic signed [HW-1:0] em, e0, e1, e2;
    em = ext(pm); e0 = ext(p0); e1 = ext(p1); e2 = ext(p2);
    coef_a = e2 - ((e1 <<< 1) + e1) + ((e0 <<< 1) + e0) - em;
  endfunction

  assign in_ready  = (state_r == crps_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign in_xfer   = in_valid && in_ready;

  assign fetch_j   = {2'b00, seg_r} + 10'(cnt_r);
  assign fetch_idx = fetch_j - 10'd1;
  assign fetch_ok  = (fetch_j != 10'd0) && (32'(fetch_idx) < MAX_POINTS);
  assign load_ok   = 32'(in_data.point_index) < MAX_POINTS;

  assign mem_addr = (state_r == crps_pkg::ST_IDLE) ? AW'(in_data.point_index)
                                                   : AW'(fetch_idx);
  assign mem_we   = in_xfer && (in_data.func == crps_pkg::FUNC_LOAD) && load_ok;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_x[mem_addr] <= CB'(in_data.point_x);
      mem_y[mem_addr] <= CB'(in_data.point_y);
    end
    rd_x_r <= mem_x[mem_addr];
    rd_y_r <= mem_y[mem_addr];
  end

  // Arithmetic shared by the sequencer
  assign seg10  = {2'b00, seg_r};
  assign pc10   = {1'b0, pc_r};
  assign tsum   = {1'b0, t_r} + {1'b0, inc_r};
  assign tdiff  = t_r - inc_r;
  assign seg_up = seg_r + 8'd1;
  assign seg_dn = seg_r - 8'd1;

  assign dx_s = {p1_x_r[CB-1], p1_x_r} - {p0_x_r[CB-1], p0_x_r};
  assign dy_s = {p1_y_r[CB-1], p1_y_r} - {p0_y_r[CB-1], p0_y_r};
  assign dx_m = dx_s[CB] ? -dx_s : dx_s;
  assign dy_m = dy_s[CB] ? -dy_s : dy_s;

  assign rem_sh = {srem_r[RW-1:0], acc_r[NW-1:NW-2]};
  assign trial  = {root_r, 2'b01};

  assign dsh = {drem_r[DVW-2:0], 1'b0};
  assign dvs = div_snap_r ? DVW'(inc_r) : DVW'(root_r);

  assign rdx = rvld_r ? rd_x_r : '0;
  assign rdy = rvld_r ? rd_y_r : '0;

  assign a_x = coef_a(pm_x_r, p0_x_r, p1_x_r, p2_x_r);
  assign a_y = coef_a(pm_y_r, p0_y_r, p1_y_r, p2_y_r);

  always_comb begin
    logic signed [HW-1:0] em, e0, e1, e2;
    em = coord_r ? ext(pm_y_r) : ext(pm_x_r);
    e0 = coord_r ? ext(p0_y_r) : ext(p0_x_r);
    e1 = coord_r ? ext(p1_y_r) : ext(p1_x_r);
    e2 = coord_r ? ext(p2_y_r) : ext(p2_x_r);
    unique case (cnt_r[1:0])
      2'd0:    coef = -e2 + (e1 <<< 2) - ((e0 <<< 2) + e0) + (em <<< 1);
      2'd1:    coef = e1 - em;
      default: coef = e0 <<< 1;
    endcase
  end

  // One Horner step: floor(acc*t / 2^16) + next coefficient
  assign prod = hacc_r * $signed({1'b0, t_r});
  assign mt   = prod[HW+15:16];
  assign hsum = mt + coef;
  assign half = hsum >>> 1;
  always_comb begin
    if ((&half[HW-1:CB-1]) || !(|half[HW-1:CB-1])) begin
      sat = half[CB-1:0];
    end else if (half[HW-1]) begin
      sat = {1'b1, {(CB-1){1'b0}}};
    end else begin
      sat = {1'b0, {(CB-1){1'b1}}};
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    seg_nxt      = seg_r;
    t_nxt        = t_r;
    inc_nxt      = inc_r;
    cur_x_nxt    = cur_x_r;
    cur_y_nxt    = cur_y_r;
    step_nxt     = step_r;
    end_nxt      = end_r;
    pc_nxt       = pc_r;
    ok_nxt       = ok_r;
    need_inc_nxt = need_inc_r;
    tmode_nxt    = tmode_r;
    tgt_nxt      = tgt_r;
    pm_x_nxt = pm_x_r; p0_x_nxt = p0_x_r; p1_x_nxt = p1_x_r; p2_x_nxt = p2_x_r;
    pm_y_nxt = pm_y_r; p0_y_nxt = p0_y_r; p1_y_nxt = p1_y_r; p2_y_nxt = p2_y_r;
    acc_nxt      = acc_r;
    sqa_nxt      = sqa_r;
    sqb_nxt      = sqb_r;
    pass_nxt     = pass_r;
    root_nxt     = root_r;
    srem_nxt     = srem_r;
    drem_nxt     = drem_r;
    q_nxt        = q_r;
    q_fin        = q_r;
    div_snap_nxt = div_snap_r;
    hacc_nxt     = hacc_r;
    coord_nxt    = coord_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    if (cfg_valid) begin
      unique case (cfg_index)
        crps_pkg::REG_STEP_SIZE:   step_nxt = cfg_data[30:0];
        crps_pkg::REG_END_STEP:    end_nxt  = cfg_data[30:0];
        crps_pkg::REG_POINT_COUNT: pc_nxt   = cfg_data[8:0];
        default: ;
      endcase
    end

    unique case (state_r)
      crps_pkg::ST_IDLE: begin
        if (in_xfer) begin
          ok_nxt       = 1'b1;
          need_inc_nxt = 1'b0;
          tmode_nxt    = crps_pkg::TM_KEEP;
          tgt_nxt      = step_r;
          cnt_nxt      = '0;
          state_nxt    = crps_pkg::ST_FETCH;
          unique case (in_data.func)
            crps_pkg::FUNC_LOAD: begin
              state_nxt = crps_pkg::ST_DONE;
            end
            crps_pkg::FUNC_RESTART: begin
              seg_nxt      = 8'd1;
              t_nxt        = '0;
              need_inc_nxt = 1'b1;
            end
            crps_pkg::FUNC_FWD: begin
              if (tsum > 18'(crps_pkg::T_ONE)) begin
                if (seg10 + 10'd4 >= pc10) begin
                  ok_nxt    = 1'b0;
                  state_nxt = crps_pkg::ST_DONE;
                end else begin
                  // move on; last usable segment uses the end step size
                  seg_nxt      = seg_up;
                  need_inc_nxt = 1'b1;
                  tmode_nxt    = crps_pkg::TM_INC;
                  if (10'(seg_up) + 10'd3 == pc10) begin
                    tgt_nxt = end_r;
                  end
                end
              end else begin
                t_nxt = tsum[16:0];
              end
            end
            default: begin
              // back: landing on t=0 falls through to the previous segment
              if (t_r < inc_r || tdiff == 17'd0) begin
                if (t_r >= inc_r) begin
                  t_nxt = '0;
                end
                if (seg_r <= 8'd3) begin
                  ok_nxt    = 1'b0;
                  state_nxt = crps_pkg::ST_DONE;
                end else begin
                  seg_nxt      = seg_dn;
                  need_inc_nxt = 1'b1;
                  tmode_nxt    = crps_pkg::TM_SNAP;
                end
              end else begin
                t_nxt = tdiff;
              end
            end
          endcase
        end
      end

      crps_pkg::ST_FETCH: begin
        // shift in pm, p0, p1, p2 as their reads come back
        if (cnt_r != '0) begin
          pm_x_nxt = p0_x_r; p0_x_nxt = p1_x_r; p1_x_nxt = p2_x_r; p2_x_nxt = rdx;
          pm_y_nxt = p0_y_r; p0_y_nxt = p1_y_r; p1_y_nxt = p2_y_r; p2_y_nxt = rdy;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNTW'(4)) begin
          state_nxt = need_inc_r ? crps_pkg::ST_CHORD : crps_pkg::ST_PLACE;
        end
      end

      crps_pkg::ST_CHORD: begin
        if (seg10 + 10'd1 > pc10) begin
          inc_nxt   = crps_pkg::T_ONE;
          state_nxt = crps_pkg::ST_INC;
        end else begin
          acc_nxt   = '0;
          sqa_nxt   = NW'(dx_m);
          sqb_nxt   = dx_m;
          pass_nxt  = 1'b0;
          cnt_nxt   = '0;
          state_nxt = crps_pkg::ST_SQ;
        end
      end

      crps_pkg::ST_SQ: begin
        // shift-add squaring, dx then dy into one accumulator
        if (sqb_r[0]) begin
          acc_nxt = acc_r + sqa_r;
        end
        sqa_nxt = sqa_r << 1;
        sqb_nxt = sqb_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNTW'(CB)) begin
          cnt_nxt = '0;
          if (!pass_r) begin
            pass_nxt = 1'b1;
            sqa_nxt  = NW'(dy_m);
            sqb_nxt  = dy_m;
          end else begin
            root_nxt  = '0;
            srem_nxt  = '0;
            state_nxt = crps_pkg::ST_SQRT;
          end
        end
      end

      crps_pkg::ST_SQRT: begin
        // one root bit per cycle, two radicand bits consumed
        acc_nxt = acc_r << 2;
        if (rem_sh >= trial) begin
          srem_nxt = rem_sh - trial;
          root_nxt = {root_r[RW-2:0], 1'b1};
        end else begin
          srem_nxt = rem_sh;
          root_nxt = {root_r[RW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNTW'(RW - 1)) begin
          state_nxt = crps_pkg::ST_CHK;
        end
      end

      crps_pkg::ST_CHK: begin
        if (CW'(tgt_r) >= CW'(root_r)) begin
          inc_nxt   = crps_pkg::T_ONE;
          state_nxt = crps_pkg::ST_INC;
        end else begin
          drem_nxt     = DVW'(tgt_r);
          q_nxt        = '0;
          div_snap_nxt = 1'b0;
          cnt_nxt      = '0;
          state_nxt    = crps_pkg::ST_DIV;
        end
      end

      crps_pkg::ST_DIV: begin
        // restoring divide, 16 quotient bits
        if (dsh >= dvs) begin
          drem_nxt = dsh - dvs;
          q_fin    = {q_r[14:0], 1'b1};
        end else begin
          drem_nxt = dsh;
          q_fin    = {q_r[14:0], 1'b0};
        end
        q_nxt   = q_fin;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNTW'(15)) begin
          if (div_snap_r) begin
            t_nxt     = crps_pkg::T_ONE - 17'(drem_nxt);
            state_nxt = crps_pkg::ST_PLACE;
          end else begin
            inc_nxt   = (q_fin == 16'd0) ? 17'd1 : {1'b0, q_fin};
            state_nxt = crps_pkg::ST_INC;
          end
        end
      end

      crps_pkg::ST_INC: begin
        state_nxt = crps_pkg::ST_PLACE;
        unique case (tmode_r)
          crps_pkg::TM_INC: t_nxt = inc_r;
          crps_pkg::TM_SNAP: begin
            if (inc_r == 17'd1) begin
              t_nxt = crps_pkg::T_ONE;
            end else begin
              // t = 1 - (1 mod inc)
              drem_nxt     = DVW'(1);
              q_nxt        = '0;
              div_snap_nxt = 1'b1;
              cnt_nxt      = '0;
              state_nxt    = crps_pkg::ST_DIV;
            end
          end
          default: ;
        endcase
      end

      crps_pkg::ST_PLACE: begin
        if (seg10 + 10'd2 <= pc10) begin
          hacc_nxt  = a_x;
          coord_nxt = 1'b0;
          cnt_nxt   = '0;
          state_nxt = crps_pkg::ST_EVAL;
        end else begin
          state_nxt = crps_pkg::ST_DONE;
        end
      end

      crps_pkg::ST_EVAL: begin
        hacc_nxt = hsum;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNTW'(2)) begin
          cnt_nxt = '0;
          if (!coord_r) begin
            cur_x_nxt = sat;
            hacc_nxt  = a_y;
            coord_nxt = 1'b1;
          end else begin
            cur_y_nxt = sat;
            state_nxt = crps_pkg::ST_DONE;
          end
        end
      end

      crps_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt        = 1'b1;
          out_data_nxt.ok      = ok_r;
          out_data_nxt.pos_x   = 32'(cur_x_r);
          out_data_nxt.pos_y   = 32'(cur_y_r);
          out_data_nxt.segment = seg_r;
          out_data_nxt.param   = {1'b0, t_r};
          state_nxt            = crps_pkg::ST_IDLE;
        end
      end

      default: state_nxt = crps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= crps_pkg::ST_IDLE;
      seg_r       <= 8'd1;
      t_r         <= '0;
      inc_r       <= crps_pkg::T_ONE;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      step_r      <= 31'd65536;
      end_r       <= 31'd65536;
      pc_r        <= 9'd4;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seg_r       <= seg_nxt;
      t_r         <= t_nxt;
      inc_r       <= inc_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      step_r      <= step_nxt;
      end_r       <= end_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    ok_r       <= ok_nxt;
    need_inc_r <= need_inc_nxt;
    tmode_r    <= tmode_nxt;
    tgt_r      <= tgt_nxt;
    pm_x_r <= pm_x_nxt; p0_x_r <= p0_x_nxt; p1_x_r <= p1_x_nxt; p2_x_r <= p2_x_nxt;
    pm_y_r <= pm_y_nxt; p0_y_r <= p0_y_nxt; p1_y_r <= p1_y_nxt; p2_y_r <= p2_y_nxt;
    rvld_r     <= fetch_ok;
    acc_r      <= acc_nxt;
    sqa_r      <= sqa_nxt;
    sqb_r      <= sqb_nxt;
    pass_r     <= pass_nxt;
    root_r     <= root_nxt;
    srem_r     <= srem_nxt;
    drem_r     <= drem_nxt;
    q_r        <= q_nxt;
    div_snap_r <= div_snap_nxt;
    hacc_r     <= hacc_nxt;
    coord_r    <= coord_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ----- src/crps_checker.sv -----
// Port-level checks of the Catmull-Rom path stepper, bound to its top level.
module crps_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input crps_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken while another is in work");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_param: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.param <= {1'b0, crps_pkg::T_ONE})
    else $error("t above one");

endmodule

bind catmull_rom_path_stepper crps_checker u_crps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- test/tb_catmull_rom_path_stepper.sv -----
// Self-checking testbench for the Catmull-Rom path stepper.
module tb_catmull_rom_path_stepper;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  crps_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  crps_pkg::out_item_t out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [1:0]          cfg_index;
  logic [31:0]         cfg_data;

  catmull_rom_path_stepper i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Settle time after the last result before touching a register; it is meant
  // to cover a segment change with a snap divide.
  localparam int SETTLE_CYCLES = 300;

  // ---------------------------------------------------------------------
  // Path model: point store, position state and configuration
  // ---------------------------------------------------------------------
  longint    path_x [256];
  longint    path_y [256];
  int        cur_seg;
  int        cur_t;
  int        cur_inc;
  longint    pos_x;
  longint    pos_y;
  int        step_len;
  int        end_len;
  int        n_points;

  crps_pkg::out_item_t pending_results[$];
  int        n_errors;
  int        n_sent;
  int        n_received;
  int        n_refused;
  int        n_seg_moves;

  // Read a point; anything outside the store reads as zero.
  function automatic longint point_at(bit use_y, int idx);
    if (idx < 0 || idx >= 256) return 0;
    return use_y ? path_y[idx] : path_x[idx];
  endfunction

  // Floored integer square root of the squared chord of segment i.
  function automatic longint chord_of(int i);
    longint     dx;
    longint     dy;
    logic [127:0] sq;
    logic [127:0] root;
    logic [127:0] cand;
    dx = point_at(0, i + 1) - point_at(0, i);
    dy = point_at(1, i + 1) - point_at(1, i);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    sq = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
    root = '0;
    for (int b = 52; b >= 0; b--) begin
      cand = root | (128'd1 << b);
      if (cand * cand <= sq) root = cand;
    end
    return longint'(root);
  endfunction

  // t increment for segment i at the given travel per step.
  function automatic int incr_of(int i, int target);
    longint len;
    longint q;
    if (i + 1 > n_points) return int'(crps_pkg::T_ONE);
    len = chord_of(i);
    if (longint'(target) >= len) return int'(crps_pkg::T_ONE);
    q = (longint'(target) <<< 16) / len;
    return (q == 0) ? 1 : int'(q);
  endfunction

  // Floor of v*t in Q16.16 with t in Q1.16.
  function automatic longint scale_t(longint v, int t);
    return (v * longint'(t)) >>> 16;
  endfunction

  function automatic longint spline_at(bit use_y, int i, int t);
    longint pm;
    longint p0;
    longint p1;
    longint p2;
    longint u;
    pm = point_at(use_y, i - 1);
    p0 = point_at(use_y, i);
    p1 = point_at(use_y, i + 1);
    p2 = point_at(use_y, i + 2);
    u = scale_t(p2 - 3 * p1 + 3 * p0 - pm, t) + (-p2 + 4 * p1 - 5 * p0 + 2 * pm);
    u = scale_t(u, t) + (p1 - pm);
    u = scale_t(u, t) + 2 * p0;
    u = u >>> 1;
    if (u > 64'sd2147483647) u = 64'sd2147483647;
    if (u < -64'sd2147483648) u = -64'sd2147483648;
    return u;
  endfunction

  // Re-evaluate the position unless the segment runs past the loaded points.
  function automatic void update_position();
    if (cur_seg + 2 <= n_points) begin
      pos_x = spline_at(0, cur_seg, cur_t);
      pos_y = spline_at(1, cur_seg, cur_t);
    end
  endfunction

  function automatic bit step_forward();
    if (cur_t + cur_inc > int'(crps_pkg::T_ONE) && cur_seg + 4 >= n_points) return 0;
    cur_t += cur_inc;
    if (cur_t > int'(crps_pkg::T_ONE)) begin
      cur_seg = (cur_seg + 1) & 8'hFF;
      cur_inc = incr_of(cur_seg, (cur_seg == n_points - 3) ? end_len : step_len);
      cur_t = cur_inc;
      n_seg_moves++;
    end
    update_position();
    return 1;
  endfunction

  // Landing exactly on t=0 steps back once more.
  function automatic bit step_back();
    forever begin
      if (cur_t < cur_inc) begin
        if (cur_seg <= 3) return 0;
        cur_seg = (cur_seg - 1) & 8'hFF;
        cur_inc = incr_of(cur_seg, step_len);
        cur_t = (int'(crps_pkg::T_ONE) / cur_inc) * cur_inc;
        n_seg_moves++;
        break;
      end
      cur_t -= cur_inc;
      if (cur_t != 0) break;
    end
    update_position();
    return 1;
  endfunction

  // Apply one command to the model and return the result it must produce.
  function automatic crps_pkg::out_item_t apply_command(crps_pkg::in_item_t cmd);
    crps_pkg::out_item_t r;
    bit                  done;
    done = 1;
    case (cmd.func)
      crps_pkg::FUNC_LOAD: begin
        path_x[cmd.point_index] = longint'(cmd.point_x);
        path_y[cmd.point_index] = longint'(cmd.point_y);
      end
      crps_pkg::FUNC_RESTART: begin
        cur_seg = 1;
        cur_t   = 0;
        cur_inc = incr_of(1, step_len);
        update_position();
      end
      crps_pkg::FUNC_FWD: done = step_forward();
      default:            done = step_back();
    endcase
    if (!done) n_refused++;
    r.ok      = done;
    r.pos_x   = pos_x[31:0];
    r.pos_y   = pos_y[31:0];
    r.segment = cur_seg[7:0];
    r.param   = cur_t[17:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Clock, reset and limit
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("Timeout: %0d results still outstanding", pending_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Result side: stall pattern and checker
  // ---------------------------------------------------------------------
  // Stall on a pattern of its own: switch at random among always ready, light
  // and heavy stalling.
  initial begin
    int mode;
    int left;
    out_ready = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(10, 60);
      end
      left--;
      case (mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    crps_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      n_received++;
      if (pending_results.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("Unexpected result transfer: %p", out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data.ok !== want.ok || out_data.pos_x !== want.pos_x ||
            out_data.pos_y !== want.pos_y || out_data.segment !== want.segment ||
            out_data.param !== want.param) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("Mismatch at result %0d", n_received);
            $display("  expected ok=%0b x=%0d y=%0d seg=%0d t=%0d", want.ok,
                     want.pos_x, want.pos_y, want.segment, want.param);
            $display("  actual   ok=%0b x=%0d y=%0d seg=%0d t=%0d", out_data.ok,
                     out_data.pos_x, out_data.pos_y, out_data.segment, out_data.param);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------
  int burst_left;

  // Send one command in bursts with random gaps; predict on transfer.
  task automatic send_command(crps_pkg::in_item_t cmd, bit typed,
                              crps_pkg::out_item_t typed_result);
    crps_pkg::out_item_t predicted;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk); while (!(in_valid && in_ready));
    predicted = apply_command(cmd);
    pending_results.push_back(typed ? typed_result : predicted);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic send(crps_pkg::func_t f, int idx, int x, int y);
    crps_pkg::in_item_t  cmd;
    crps_pkg::out_item_t none;
    cmd.func        = f;
    cmd.point_index = idx[7:0];
    cmd.point_x     = x;
    cmd.point_y     = y;
    none = '0;
    send_command(cmd, 1'b0, none);
  endtask

  // Hold until every result is back, then let the block finish its work.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      crps_pkg::REG_STEP_SIZE: step_len = value & 32'h7FFF_FFFF;
      crps_pkg::REG_END_STEP:  end_len  = value & 32'h7FFF_FFFF;
      default:                 n_points = value & 32'h1FF;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly modest coordinates so chords sit near the step size; some full-range.
  function automatic int rand_coord(int around);
    case ($urandom_range(0, 9))
      0:       return int'($urandom());
      1, 2:    return around + int'($urandom_range(0, 1 << 26)) - (1 << 25);
      default: return around + int'($urandom_range(0, 1 << 19)) - (1 << 18);
    endcase
  endfunction

  // Directed stimulus: straight path of unit spacing, then the corner cases.
  typedef struct {
    crps_pkg::func_t     f;
    int                  idx;
    int                  x;
    int                  y;
    bit                  typed;
    crps_pkg::out_item_t res;
  } plan_row_t;

  plan_row_t plan[$];

  function automatic void add_row(crps_pkg::func_t f, int idx, int x, int y, bit typed,
                                  bit ok, int px, int py, int seg, int t);
    plan_row_t r;
    r.f = f;
    r.idx = idx;
    r.x = x;
    r.y = y;
    r.typed = typed;
    r.res.ok = ok;
    r.res.pos_x = px;
    r.res.pos_y = py;
    r.res.segment = seg[7:0];
    r.res.param = t[17:0];
    plan.push_back(r);
  endfunction

  initial begin
    crps_pkg::in_item_t cmd;
    int                 pick;
    int                 phase_items;
    int                 last;
    int                 walk;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = crps_pkg::REG_STEP_SIZE;
    cfg_data = '0;
    n_errors = 0;
    n_sent = 0;
    n_received = 0;
    n_refused = 0;
    n_seg_moves = 0;
    burst_left = 0;
    step_len = 65536;
    end_len = 65536;
    n_points = 4;
    cur_seg = 1;
    cur_t = 0;
    cur_inc = int'(crps_pkg::T_ONE);
    pos_x = 0;
    pos_y = 0;
    foreach (path_x[i]) begin
      path_x[i] = 0;
      path_y[i] = 0;
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Points 0..3 on the x axis, one unit apart; loads report the reset position.
    for (int k = 0; k < 4; k++)
      add_row(crps_pkg::FUNC_LOAD, k, k * 65536, 0, 1, 1, 0, 0, 1, 0);
    add_row(crps_pkg::FUNC_RESTART, 0, 0, 0, 1, 1, 65536, 0, 1, 0);
    add_row(crps_pkg::FUNC_FWD, 0, 0, 0, 1, 1, 131072, 0, 1, 65536);
    // Past t=1 on the last usable segment: refused.
    add_row(crps_pkg::FUNC_FWD, 0, 0, 0, 1, 0, 131072, 0, 1, 65536);
    // Back onto t=0 steps again, which is refused at segment 1.
    add_row(crps_pkg::FUNC_BACK, 0, 0, 0, 1, 0, 131072, 0, 1, 0);
    add_row(crps_pkg::FUNC_BACK, 0, 0, 0, 1, 0, 131072, 0, 1, 0);
    // Field extremes and the top store entry.
    add_row(crps_pkg::FUNC_LOAD, 255, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 0, 0);
    add_row(crps_pkg::FUNC_LOAD, 254, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0);
    add_row(crps_pkg::FUNC_LOAD, 4, -1, -1, 0, 0, 0, 0, 0, 0);
    add_row(crps_pkg::FUNC_LOAD, 5, 32'h5555_5555, 32'hAAAA_AAAA, 0, 0, 0, 0, 0, 0);
    add_row(crps_pkg::FUNC_LOAD, 6, 32'hAAAA_AAAA, 32'h5555_5555, 0, 0, 0, 0, 0, 0);
    add_row(crps_pkg::FUNC_LOAD, 7, 3 * 65536, 65536, 0, 0, 0, 0, 0, 0);
    add_row(crps_pkg::FUNC_RESTART, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(crps_pkg::FUNC_FWD, 0, 0, 0, 0, 0, 0, 0, 0, 0);

    foreach (plan[i]) begin
      cmd.func = plan[i].f;
      cmd.point_index = plan[i].idx[7:0];
      cmd.point_x = plan[i].x;
      cmd.point_y = plan[i].y;
      send_command(cmd, plan[i].typed, plan[i].res);
    end

    // Fill the whole store with a wandering path so no read hits an unwritten entry.
    walk = 0;
    for (int k = 0; k < 256; k++) begin
      walk = rand_coord(walk);
      send(crps_pkg::FUNC_LOAD, k, walk, rand_coord(k * 65536));
    end
    drain();

    // Phases over register settings, extremes included.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(crps_pkg::REG_STEP_SIZE, 1);
          write_reg(crps_pkg::REG_END_STEP, 1);
          write_reg(crps_pkg::REG_POINT_COUNT, 4);
        end
        1: begin
          write_reg(crps_pkg::REG_STEP_SIZE, 32'h7FFF_FFFF);
          write_reg(crps_pkg::REG_END_STEP, 32'h7FFF_FFFF);
          write_reg(crps_pkg::REG_POINT_COUNT, 256);
        end
        2: begin
          write_reg(crps_pkg::REG_STEP_SIZE, 1 << 17);
          write_reg(crps_pkg::REG_END_STEP, 1 << 15);
          write_reg(crps_pkg::REG_POINT_COUNT, 12);
        end
        3: begin
          write_reg(crps_pkg::REG_STEP_SIZE, 1 << 16);
          write_reg(crps_pkg::REG_END_STEP, 1 << 18);
          write_reg(crps_pkg::REG_POINT_COUNT, 256);
        end
        default: begin
          write_reg(crps_pkg::REG_STEP_SIZE, $urandom_range(1 << 14, 1 << 20));
          write_reg(crps_pkg::REG_END_STEP, $urandom_range(1, 32'h7FFF_FFFF));
          write_reg(crps_pkg::REG_POINT_COUNT, $urandom_range(4, 40));
        end
      endcase
      send(crps_pkg::FUNC_RESTART, 0, 0, 0);
      phase_items = 30;
      for (int k = 0; k < phase_items; k++) begin
        pick = $urandom_range(0, 19);
        if (pick < 12)      send(crps_pkg::FUNC_FWD, 0, 0, 0);
        else if (pick < 17) send(crps_pkg::FUNC_BACK, 0, 0, 0);
        else if (pick < 18) send(crps_pkg::FUNC_RESTART, 0, 0, 0);
        else begin
          last = $urandom_range(0, 255);
          send(crps_pkg::FUNC_LOAD, last, rand_coord(int'(path_x[last])),
               rand_coord(int'(path_y[last])));
        end
      end
      // Pause the sender until every result is back.
      drain();
    end

    $display("Sent %0d commands, checked %0d results over 8 register settings.",
             n_sent, n_received);
    $display("Refused steps: %0d, segment changes: %0d.", n_refused, n_seg_moves);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/crps_pkg.sv
src/catmull_rom_path_stepper.sv
src/crps_checker.sv
test/tb_catmull_rom_path_stepper.sv
